// ===== hdl/multi_slot_countdown_alarms_core_defines.svh =====
// assertion macros for the countdown alarm bank
// relies on clk_i and rst_ni being present in the module that uses them
`ifndef MULTI_SLOT_COUNTDOWN_ALARMS_CORE_DEFINES_SVH
`define MULTI_SLOT_COUNTDOWN_ALARMS_CORE_DEFINES_SVH

// checked only out of reset
`define MSCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define MSCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/msca_pkg.sv =====
// shared types and constants for the countdown alarm bank
// no dependencies
package msca_pkg;

  localparam int unsigned MaxSlots = 8;
  localparam int unsigned SlotW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned TickW    = 32;
  localparam int unsigned ModeW    = 2;

  localparam logic [ModeW-1:0] MODE_ARM    = 2'd0;
  localparam logic [ModeW-1:0] MODE_DISARM = 2'd1;
  localparam logic [ModeW-1:0] MODE_POLL   = 2'd2;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_SLOT  = 1'b1;

  // command broadcast to every slot for one step
  typedef struct packed {
    logic              arm;
    logic              disarm;
    logic              poll;
    logic [CountW-1:0] count;
    logic [CountW-1:0] elapsed;
  } msca_slot_cmd_t;

  // per slot outcome of one step
  typedef struct packed {
    logic armed_d;
    logic fired;
  } msca_slot_sts_t;

endpackage

// ===== hdl/msca_slot.sv =====
// one alarm slot: remaining count, armed bit, expiry compare and subtract
// depends on msca_pkg
module msca_slot (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    sel_i,
  input  msca_pkg::msca_slot_cmd_t cmd_i,
  output msca_pkg::msca_slot_sts_t sts_o
);
  import msca_pkg::*;

  logic [CountW-1:0] remaining_q, remaining_d;
  logic              armed_q, armed_d;
  logic              fired;

  always_comb begin
    remaining_d = remaining_q;
    armed_d     = armed_q;
    fired       = 1'b0;
    if (cmd_i.arm && sel_i) begin
      remaining_d = cmd_i.count;
      armed_d     = 1'b1;
    end else if (cmd_i.disarm && sel_i) begin
      remaining_d = '0;
      armed_d     = 1'b0;
    end else if (cmd_i.poll && armed_q) begin
      if (remaining_q < cmd_i.elapsed) begin
        fired   = 1'b1;
        armed_d = 1'b0;
      end else begin
        remaining_d = remaining_q - cmd_i.elapsed;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      armed_q     <= 1'b0;
    end else begin
      remaining_q <= remaining_d;
      armed_q     <= armed_d;
    end
  end

  assign sts_o.armed_d = armed_d;
  assign sts_o.fired   = fired;

endmodule

// ===== hdl/multi_slot_countdown_alarms_core.sv =====
// Bank of countdown alarm slots with arm, disarm and poll commands. One beat
// is taken per clock while the result side keeps taking beats: a beat is
// held in the input register, is executed against every slot in parallel
// (one 16-bit compare and subtract per slot) and lands in the result
// register. Only the low 16 bits of the tick take part in the elapsed time.
// depends on msca_pkg, msca_slot and multi_slot_countdown_alarms_core_defines.svh
`include "multi_slot_countdown_alarms_core_defines.svh"

module multi_slot_countdown_alarms_core #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [msca_pkg::ModeW-1:0]     mode_i,
  input  logic [msca_pkg::SlotW-1:0]     slot_i,
  input  logic [msca_pkg::CountW-1:0]    count_value_i,
  input  logic [msca_pkg::TickW-1:0]     tick_now_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           status_o,
  output logic [msca_pkg::MaxSlots-1:0]  armed_mask_o,
  output logic [msca_pkg::MaxSlots-1:0]  fired_mask_o
);
  import msca_pkg::*;

  // input register
  logic              in_valid_q;
  logic [ModeW-1:0]  mode_q;
  logic [SlotW-1:0]  slot_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] tick_q;

  // state and result register
  logic [CountW-1:0]   last_tick_q;
  logic                out_valid_q;
  logic                status_q;
  logic [MaxSlots-1:0] armed_mask_q;
  logic [MaxSlots-1:0] fired_mask_q;

  logic                in_accept;
  logic                advance;
  logic                step;
  logic                is_slot_op;
  logic                in_range;
  logic                status;
  msca_slot_cmd_t      cmd;
  msca_slot_sts_t      sts [MaxSlots];
  logic [MaxSlots-1:0] armed_vec;
  logic [MaxSlots-1:0] fired_vec;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  assign is_slot_op = (mode_q == MODE_ARM) || (mode_q == MODE_DISARM);
  assign in_range   = slot_q < SlotW'(SLOT_COUNT);
  assign status     = (is_slot_op && !in_range) ? STATUS_BAD_SLOT : STATUS_OK;

  always_comb begin
    cmd.arm     = step && (mode_q == MODE_ARM);
    cmd.disarm  = step && (mode_q == MODE_DISARM);
    cmd.poll    = step && (mode_q == MODE_POLL);
    cmd.count   = count_q;
    cmd.elapsed = tick_q - last_tick_q;
  end

  for (genvar i = 0; i < MaxSlots; i++) begin : g_slot
    if (i < SLOT_COUNT) begin : g_used
      msca_slot u_slot (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .sel_i  (slot_q == SlotW'(i)),
        .cmd_i  (cmd),
        .sts_o  (sts[i])
      );
    end else begin : g_unused
      assign sts[i] = '0;
    end
    assign armed_vec[i] = sts[i].armed_d;
    assign fired_vec[i] = sts[i].fired;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q  <= mode_i;
      slot_q  <= slot_i;
      count_q <= count_value_i;
      tick_q  <= tick_now_i[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tick_q <= '0;
    end else if (cmd.poll) begin
      last_tick_q <= tick_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      status_q     <= status;
      armed_mask_q <= armed_vec;
      fired_mask_q <= cmd.poll ? fired_vec : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign armed_mask_o = armed_mask_q;
  assign fired_mask_o = fired_mask_q;

  `MSCA_ASSERT(a_fired_disarmed, out_valid_q |-> ((fired_mask_q & armed_mask_q) == '0),
               "a fired slot is still armed")
  `MSCA_ASSERT(a_fire_only_on_poll, (step && (mode_q != MODE_POLL)) |=> (fired_mask_q == '0),
               "fired mask set outside a poll")
  `MSCA_ASSERT(a_error_no_fire, (out_valid_q && status_q) |-> (fired_mask_q == '0),
               "slot error together with expiry")
  `MSCA_ASSERT(a_unused_slots_idle,
               out_valid_q |-> (((armed_mask_q | fired_mask_q) >> SLOT_COUNT) == '0),
               "mask bit set for a slot that does not exist")
  `MSCA_ASSERT_ALWAYS(a_ready_when_empty, !in_valid_q |-> in_ready_o,
                      "input register empty but not ready")

endmodule

// ===== tb/sv/multi_slot_countdown_alarms_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the countdown alarm bank: directed and random commands
// with a predicting scoreboard class; depends on msca_pkg and multi_slot_countdown_alarms_core
module multi_slot_countdown_alarms_core_tb;
  import msca_pkg::*;

  localparam int unsigned          Slots      = 8;
  localparam int unsigned          RandBeats  = 550;
  localparam int unsigned          HoldCycles = 60;
  localparam int unsigned          CycleLimit = 100000;
  localparam logic [ModeW-1:0]     MODE_SPARE = 2'd3;

  typedef struct {
    logic                status;
    logic [MaxSlots-1:0] armed;
    logic [MaxSlots-1:0] fired;
  } alarm_masks_t;

  class alarm_scoreboard;
    logic [CountW-1:0]   remaining [Slots];
    logic [MaxSlots-1:0] armed;
    logic [TickW-1:0]    last_tick;
    alarm_masks_t        pending_masks [$];
    int unsigned         fails;

    function void clear_state();
      foreach (remaining[i]) remaining[i] = '0;
      armed     = '0;
      last_tick = '0;
      fails     = 0;
      pending_masks.delete();
    endfunction

    function void note_command(logic [ModeW-1:0] mode, logic [SlotW-1:0] slot,
                               logic [CountW-1:0] count, logic [TickW-1:0] tick);
      alarm_masks_t      exp;
      logic [CountW-1:0] elapsed;
      exp.status = STATUS_OK;
      exp.fired  = '0;
      case (mode)
        MODE_ARM, MODE_DISARM: begin
          if (slot >= Slots) begin
            exp.status = STATUS_BAD_SLOT;
          end else if (mode == MODE_ARM) begin
            remaining[slot] = count;
            armed[slot]     = 1'b1;
          end else begin
            remaining[slot] = '0;
            armed[slot]     = 1'b0;
          end
        end
        MODE_POLL: begin
          elapsed = CountW'(tick - last_tick);
          for (int i = 0; i < Slots; i++) begin
            if (armed[i]) begin
              if (remaining[i] < elapsed) begin
                exp.fired[i] = 1'b1;
                armed[i]     = 1'b0;
              end else begin
                remaining[i] = remaining[i] - elapsed;
              end
            end
          end
          last_tick = tick;
        end
        default: ;
      endcase
      exp.armed = armed;
      pending_masks.push_back(exp);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s expected %0h got %0h", name, exp, act);
        fails++;
      end
    endfunction

    function void check_masks(logic status, logic [MaxSlots-1:0] armed_act,
                              logic [MaxSlots-1:0] fired_act);
      alarm_masks_t exp;
      if (pending_masks.size() == 0) begin
        $error("result beat with nothing expected: status %0h armed %0h fired %0h",
               status, armed_act, fired_act);
        fails++;
      end else begin
        exp = pending_masks.pop_front();
        compare_field("status", exp.status, status);
        compare_field("armed_mask", exp.armed, armed_act);
        compare_field("fired_mask", exp.fired, fired_act);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ModeW-1:0]    mode_i;
  logic [SlotW-1:0]    slot_i;
  logic [CountW-1:0]   count_value_i;
  logic [TickW-1:0]    tick_now_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                status_o;
  logic [MaxSlots-1:0] armed_mask_o;
  logic [MaxSlots-1:0] fired_mask_o;

  alarm_scoreboard sb;
  bit              calm;
  bit              hold_req;
  int unsigned     cycles;

  multi_slot_countdown_alarms_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .slot_i        (slot_i),
    .count_value_i (count_value_i),
    .tick_now_i    (tick_now_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .armed_mask_o  (armed_mask_o),
    .fired_mask_o  (fired_mask_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_masks(status_o, armed_mask_o, fired_mask_o);
    end
  end

  task automatic send_command(input logic [ModeW-1:0] mode, input logic [SlotW-1:0] slot,
                              input logic [CountW-1:0] count, input logic [TickW-1:0] tick);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    slot_i        <= slot;
    count_value_i <= count;
    tick_now_i    <= tick;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(mode, slot, count, tick);
  endtask

  initial begin
    logic [TickW-1:0]  tick;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
    int unsigned       pick;

    sb = new;
    sb.clear_state();
    cycles        = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    out_ready_i   = 1'b0;
    mode_i        = MODE_ARM;
    slot_i        = '0;
    count_value_i = '0;
    tick_now_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, bad slots, spare mode, equal counts and tick wrap
    send_command(MODE_POLL,   8'd0,   16'd0,     32'd0);
    send_command(MODE_ARM,    8'd0,   16'd0,     32'd0);
    send_command(MODE_ARM,    8'd7,   16'hFFFF,  32'd0);
    send_command(MODE_ARM,    8'd8,   16'd5,     32'd0);
    send_command(MODE_DISARM, 8'd255, 16'd0,     32'd0);
    send_command(MODE_ARM,    8'd255, 16'hFFFF,  32'hFFFF_FFFF);
    send_command(MODE_DISARM, 8'd3,   16'd0,     32'd0);
    send_command(MODE_SPARE,  8'd2,   16'd77,    32'd99);
    send_command(MODE_POLL,   8'd0,   16'd0,     32'd0);
    send_command(MODE_POLL,   8'd0,   16'd0,     32'd1);
    send_command(MODE_ARM,    8'd1,   16'd10,    32'd0);
    send_command(MODE_ARM,    8'd2,   16'd9,     32'd0);
    send_command(MODE_POLL,   8'd0,   16'd0,     32'd11);
    send_command(MODE_POLL,   8'd255, 16'hFFFF,  32'd11);
    send_command(MODE_ARM,    8'd3,   16'd100,   32'd0);
    send_command(MODE_ARM,    8'd4,   16'd200,   32'd0);
    send_command(MODE_ARM,    8'd5,   16'hFFFF,  32'd0);
    send_command(MODE_ARM,    8'd6,   16'd1,     32'd0);
    send_command(MODE_POLL,   8'd0,   16'd0,     32'hFFFF_FFF0);
    send_command(MODE_POLL,   8'd0,   16'd0,     32'h0000_0005);
    send_command(MODE_DISARM, 8'd7,   16'd0,     32'd0);
    send_command(MODE_POLL,   8'd0,   16'd0,     32'h0000_0010);
    send_command(MODE_ARM,    8'd4,   16'h5555,  32'd0);
    send_command(MODE_ARM,    8'd6,   16'hAAAA,  32'd0);
    send_command(MODE_SPARE,  8'hFF,  16'hFFFF,  32'hFFFF_FFFF);

    // random: mostly arms and polls with small steps so slots expire
    tick = 32'h0000_0010;
    for (int n = 0; n < RandBeats; n++) begin
      calm = (n >= 150 && n < 250);
      if (n == 320) hold_req = 1'b1;
      pick = $urandom_range(99);
      slot = ($urandom_range(9) == 0) ? SlotW'($urandom_range(255)) : SlotW'($urandom_range(7));
      if ($urandom_range(9) < 7) count = CountW'($urandom_range(400));
      else count = CountW'($urandom);
      if (pick < 40) begin
        send_command(MODE_ARM, slot, count, $urandom);
      end else if (pick < 55) begin
        send_command(MODE_DISARM, slot, count, $urandom);
      end else if (pick < 93) begin
        if ($urandom_range(9) == 0) tick = $urandom;
        else tick = tick + $urandom_range(150);
        send_command(MODE_POLL, SlotW'($urandom), count, tick);
      end else begin
        send_command(MODE_SPARE, SlotW'($urandom), count, $urandom);
      end
    end
    calm = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.pending_masks.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending_masks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
